// File: design/pac_pkg.sv
package pac_pkg;

	// Partition set: the declared partitions followed by one unknown partition
	localparam int NUM_PARTITIONS  = 5;
	localparam int SHARE_FRAC_BITS = 10;
	localparam int NUM_SHARE_REGS  = 4;
	localparam int NUM_DECLARED    = (NUM_PARTITIONS - 1 < NUM_SHARE_REGS) ?
		NUM_PARTITIONS - 1 : NUM_SHARE_REGS;

	// Field and state widths
	localparam int CNT_W       = 16;
	localparam int SHARE_W     = 11;
	localparam int OP_W        = 2;
	localparam int PART_W      = 3;
	localparam int PIDX_W      = $clog2(NUM_PARTITIONS);
	localparam int SHARE_IDX_W = $clog2(NUM_SHARE_REGS);
	localparam int CFG_IDX_W   = 3;
	localparam int PROD_W      = CNT_W + SHARE_W;
	localparam int SUM_W       = PROD_W + 1;

	localparam logic [CNT_W-1:0] CNT_MAX    = '1;
	localparam logic [CNT_W-1:0] RESET_LIMIT = CNT_W'(20);
	localparam logic [SUM_W-1:0] ROUND_ADD  =
		(SUM_W'(1) << SHARE_FRAC_BITS) - SUM_W'(1);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_LIMIT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SHARE_FIRST   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_SHARE_LAST    = CFG_IDX_W'(NUM_SHARE_REGS);

	typedef enum logic [OP_W-1:0] {
		OP_ACQUIRE   = 2'd0,
		OP_RELEASE   = 2'd1,
		OP_SET_LIMIT = 2'd2,
		OP_NONE      = 2'd3
	} op_t;

	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] index;
		logic [CNT_W-1:0]     data;
	} cfg_wr_t;

	typedef struct packed {
		logic              admitted;
		logic [CNT_W-1:0]  inflight_now;
		logic [PART_W-1:0] part_echo;
		logic              underflow;
	} result_t;

endpackage

// File: design/pac_cap_calc.sv
module pac_cap_calc (
	input  logic [pac_pkg::CNT_W-1:0]   limit,
	input  logic [pac_pkg::SHARE_W-1:0] share,
	output logic [pac_pkg::CNT_W-1:0]   cap
);
	import pac_pkg::*;

	logic [PROD_W-1:0] prod;
	logic [SUM_W-1:0]  sum;
	logic [SUM_W-1:0]  quo;

	// Scale the limit by the share and round up
	assign prod = PROD_W'(limit) * PROD_W'(share);
	assign sum  = SUM_W'(prod) + ROUND_ADD;
	assign quo  = sum >> SHARE_FRAC_BITS;

	// Clamp to at least one and at most the counter range
	always_comb begin
		if (quo == '0) begin
			cap = CNT_W'(1);
		end else if (quo > SUM_W'(CNT_MAX)) begin
			cap = CNT_MAX;
		end else begin
			cap = quo[CNT_W-1:0];
		end
	end

endmodule

// File: design/pac_core.sv
module pac_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pac_pkg::cfg_wr_t             cfg,
	input  logic                         fire,
	input  pac_pkg::op_t                 op,
	input  logic [pac_pkg::PART_W-1:0]   part_index,
	input  logic [pac_pkg::CNT_W-1:0]    limit_value,
	output pac_pkg::result_t             res
);
	import pac_pkg::*;

	logic [CNT_W-1:0]   limit_q;
	logic [CNT_W-1:0]   inflight_q;
	logic [CNT_W-1:0]   busy_q [NUM_PARTITIONS];
	logic [SHARE_W-1:0] share_q [NUM_SHARE_REGS];

	logic [PIDX_W-1:0]  part_sel;
	logic [SHARE_W-1:0] share_sel;
	logic [CNT_W-1:0]   cap_sel;
	logic [CNT_W-1:0]   busy_cur;
	logic [CNT_W-1:0]   busy_nxt;
	logic [CNT_W-1:0]   inflight_nxt;
	logic [CNT_W-1:0]   limit_nxt;
	logic               acq_ok;

	// Fold any out-of-range index onto the unknown partition
	assign part_sel = (part_index >= NUM_PARTITIONS) ?
		PIDX_W'(NUM_PARTITIONS - 1) : PIDX_W'(part_index);

	// Only declared partitions carry a share; the rest get cap one
	assign share_sel = (part_sel < NUM_DECLARED) ?
		share_q[SHARE_IDX_W'(part_sel)] : '0;

	pac_cap_calc u_cap (
		.limit (limit_q),
		.share (share_sel),
		.cap   (cap_sel)
	);

	assign busy_cur = busy_q[part_sel];
	assign acq_ok   = (inflight_q < limit_q) || (busy_cur < cap_sel);

	// Work out the next counters and the result for this request
	always_comb begin
		res          = '0;
		busy_nxt     = busy_cur;
		inflight_nxt = inflight_q;
		limit_nxt    = limit_q;
		case (op)
			OP_ACQUIRE: begin
				res.part_echo = PART_W'(part_sel);
				if (acq_ok) begin
					res.admitted = 1'b1;
					if (busy_cur != CNT_MAX) begin
						busy_nxt = busy_cur + CNT_W'(1);
					end
					if (inflight_q != CNT_MAX) begin
						inflight_nxt = inflight_q + CNT_W'(1);
					end
				end
			end
			OP_RELEASE: begin
				res.part_echo = PART_W'(part_sel);
				if (busy_cur == '0) begin
					res.underflow = 1'b1;
				end else begin
					busy_nxt = busy_cur - CNT_W'(1);
				end
				if (inflight_q == '0) begin
					res.underflow = 1'b1;
				end else begin
					inflight_nxt = inflight_q - CNT_W'(1);
				end
			end
			OP_SET_LIMIT: begin
				limit_nxt = limit_value;
			end
			default: begin
			end
		endcase
		res.inflight_now = inflight_nxt;
	end

	// Global limit: loaded by configuration or by a limit update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= RESET_LIMIT;
		end else if (cfg.we && cfg.index == CFG_INITIAL_LIMIT) begin
			limit_q <= cfg.data;
		end else if (fire) begin
			limit_q <= limit_nxt;
		end
	end

	// Share registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SHARE_REGS; i++) begin
				share_q[i] <= '0;
			end
		end else if (cfg.we && cfg.index inside {[CFG_SHARE_FIRST:CFG_SHARE_LAST]}) begin
			share_q[SHARE_IDX_W'(cfg.index - CFG_SHARE_FIRST)] <= cfg.data[SHARE_W-1:0];
		end
	end

	// Inflight and busy counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
			for (int i = 0; i < NUM_PARTITIONS; i++) begin
				busy_q[i] <= '0;
			end
		end else if (fire) begin
			inflight_q       <= inflight_nxt;
			busy_q[part_sel] <= busy_nxt;
		end
	end

endmodule

// File: design/partitioned_concurrency_admission_top.sv
// Each request is held in the input register and its result in the result register.
// Throughput: one request per cycle unless out_ready stalls; the input and result registers sit
// around a single multiply, round and compare path for the selected partition cap.
// Reset (arst_n, asynchronous, active low): limit 20, all shares, counters and
// valids cleared; requests are taken as soon as reset is released.
module partitioned_concurrency_admission_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pac_pkg::CNT_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pac_pkg::OP_W-1:0]      opcode,
	input  logic [pac_pkg::PART_W-1:0]    part_index,
	input  logic [pac_pkg::CNT_W-1:0]     limit_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          admitted,
	output logic [pac_pkg::CNT_W-1:0]     inflight_now,
	output logic [pac_pkg::PART_W-1:0]    part_echo,
	output logic                          underflow
);
	import pac_pkg::*;

	logic              valid_s1;
	op_t               opcode_s1;
	logic [PART_W-1:0] part_index_s1;
	logic [CNT_W-1:0]  limit_value_s1;
	logic              fire;
	logic              out_valid_q;
	result_t           result_q;
	result_t           res;
	cfg_wr_t           cfg;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// Process the held request when the result register is free or draining
	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1      <= op_t'(opcode);
			part_index_s1  <= part_index;
			limit_value_s1 <= limit_value;
		end
	end

	pac_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.fire        (fire),
		.op          (opcode_s1),
		.part_index  (part_index_s1),
		.limit_value (limit_value_s1),
		.res         (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign admitted     = result_q.admitted;
	assign inflight_now = result_q.inflight_now;
	assign part_echo    = result_q.part_echo;
	assign underflow    = result_q.underflow;

endmodule
